[rtl/rgsc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgsc_pkg
// Types, codes and constants shared by the RSSI gain search calibrator.
// ----------------------------------------------------------------------------
package rgsc_pkg;

  localparam int RSSI_W           = 16;
  localparam int AMP_W            = 6;
  localparam int PGA_W            = 5;

  localparam int SAMPLES_PER_READ = 4;
  localparam int SKIPPED_SAMPLES  = 1;

  localparam int IDX_W    = $clog2(SAMPLES_PER_READ);
  localparam int SUM_W    = RSSI_W + $clog2(SAMPLES_PER_READ);
  localparam int KEPT_DIV = (SAMPLES_PER_READ > SKIPPED_SAMPLES) ?
                            (SAMPLES_PER_READ - SKIPPED_SAMPLES) : 1;
  // sum / KEPT_DIV as (sum * DIV_MUL) >> DIV_SHIFT, exact for every sum below 2**SUM_W
  localparam int DIV_SHIFT = SUM_W + $clog2(KEPT_DIV) + 1;
  localparam int MUL_W     = DIV_SHIFT + 1;
  localparam logic [MUL_W-1:0] DIV_MUL =
    MUL_W'((2 ** DIV_SHIFT + KEPT_DIV - 1) / KEPT_DIV);

  localparam logic [AMP_W-1:0]  AMP_START    = AMP_W'(32);
  localparam logic [AMP_W-1:0]  STEP_START   = AMP_W'(32);
  localparam logic [PGA_W-1:0]  PGA_MAX      = PGA_W'(31);
  localparam logic [PGA_W:0]    PGA_RETRY_UP = (PGA_W + 1)'(6);
  localparam logic [RSSI_W-1:0] THR_RESET    = RSSI_W'(52428);

  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;

  // command codes
  localparam logic CMD_START  = 1'b0;
  localparam logic CMD_SAMPLE = 1'b1;

  // register indexes (paddr[2])
  localparam logic REG_THRESHOLD = 1'b0;
  localparam logic REG_START_PGA = 1'b1;

  typedef enum logic [1:0] {
    PH_IDLE         = 2'd0,
    PH_SEARCH       = 2'd1,
    PH_FINAL        = 2'd2,
    PH_FINAL_GAVEUP = 2'd3
  } phase_e;

  typedef struct packed {
    logic              group_end;
    logic [RSSI_W-1:0] avg;
  } acc_res_t;

  typedef struct packed {
    logic [AMP_W-1:0]  amp_gain;
    logic [PGA_W-1:0]  pga_gain;
    logic              apply_gain;
    logic              done_res;
    logic              gave_up;
    logic [RSSI_W-1:0] final_rssi;
    logic [RSSI_W-1:0] peak_rssi;
  } result_t;

endpackage

[rtl/rgsc_regs.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgsc_regs
// APB configuration registers: RSSI threshold and start PGA gain.
// ----------------------------------------------------------------------------
module rgsc_regs import rgsc_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  output logic [RSSI_W-1:0]     threshold_o,
  output logic [PGA_W-1:0]      start_pga_o
);

  logic [RSSI_W-1:0] thr_q, thr_d;
  logic [PGA_W-1:0]  spga_q, spga_d;
  logic              wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;

  always_comb begin
    thr_d  = thr_q;
    spga_d = spga_q;
    if (wr_en) begin
      case (paddr[2])
        REG_THRESHOLD: thr_d  = pwdata[RSSI_W-1:0];
        REG_START_PGA: spga_d = pwdata[PGA_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_THRESHOLD: prdata = APB_DATA_W'(thr_q);
      REG_START_PGA: prdata = APB_DATA_W'(spga_q);
      default:       prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q  <= THR_RESET;
      spga_q <= '0;
    end else begin
      thr_q  <= thr_d;
      spga_q <= spga_d;
    end
  end

  assign threshold_o = thr_q;
  assign start_pga_o = spga_q;

endmodule

[rtl/rgsc_accum.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgsc_accum
// Sample grouping: drops the leading samples of a group, sums the rest and
// divides by the kept count with a reciprocal multiply.
// ----------------------------------------------------------------------------
module rgsc_accum import rgsc_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              clear_i,
  input  logic              en_i,
  input  logic [RSSI_W-1:0] sample_i,
  output acc_res_t          acc_o
);

  logic [IDX_W-1:0]       idx_q, idx_d;
  logic [SUM_W-1:0]       sum_q, sum_d;
  logic [SUM_W-1:0]       sum_next;
  logic [SUM_W+MUL_W-1:0] prod;
  logic                   keep;
  logic                   group_end;

  assign keep      = {1'b0, idx_q} >= (IDX_W + 1)'(SKIPPED_SAMPLES);
  assign sum_next  = sum_q + (keep ? SUM_W'(sample_i) : '0);
  assign group_end = idx_q == IDX_W'(SAMPLES_PER_READ - 1);
  assign prod      = (SUM_W + MUL_W)'(sum_next) * (SUM_W + MUL_W)'(DIV_MUL);

  always_comb begin
    idx_d = idx_q;
    sum_d = sum_q;
    if (clear_i) begin
      idx_d = '0;
      sum_d = '0;
    end else if (en_i) begin
      if (group_end) begin
        idx_d = '0;
        sum_d = '0;
      end else begin
        idx_d = idx_q + 1'b1;
        sum_d = sum_next;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
      sum_q <= '0;
    end else begin
      idx_q <= idx_d;
      sum_q <= sum_d;
    end
  end

  assign acc_o.group_end = group_end;
  assign acc_o.avg       = prod[DIV_SHIFT +: RSSI_W];

endmodule

[rtl/rgsc_search.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgsc_search
// Binary search on the amp gain, PGA retry and final measurement control.
// ----------------------------------------------------------------------------
module rgsc_search import rgsc_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              fire_i,
  input  logic              command_i,
  input  acc_res_t          acc_i,
  input  logic [RSSI_W-1:0] threshold_i,
  input  logic [PGA_W-1:0]  start_pga_i,
  output logic              active_o,
  output result_t           res_o
);

  phase_e            phase_q, phase_d;
  logic [AMP_W-1:0]  amp_q, amp_d;
  logic [AMP_W-1:0]  step_q, step_d;
  logic [AMP_W-1:0]  blow_q, blow_d;
  logic [AMP_W-1:0]  bhigh_q, bhigh_d;
  logic              blow_vld_q, blow_vld_d;
  logic              bhigh_vld_q, bhigh_vld_d;
  logic [PGA_W-1:0]  pga_q, pga_d;
  logic [RSSI_W-1:0] peak_q, peak_d;
  logic [AMP_W-1:0]  half;
  logic [PGA_W:0]    pga_up;

  assign half     = step_q >> 1;
  assign pga_up   = {1'b0, pga_q} + PGA_RETRY_UP;
  assign active_o = phase_q != PH_IDLE;

  always_comb begin
    phase_d     = phase_q;
    amp_d       = amp_q;
    step_d      = step_q;
    blow_d      = blow_q;
    bhigh_d     = bhigh_q;
    blow_vld_d  = blow_vld_q;
    bhigh_vld_d = bhigh_vld_q;
    pga_d       = pga_q;
    peak_d      = peak_q;
    res_o.apply_gain = 1'b0;
    res_o.done_res   = 1'b0;
    res_o.gave_up    = 1'b0;
    res_o.final_rssi = '0;

    if (fire_i) begin
      if (command_i == CMD_START) begin
        pga_d       = start_pga_i;
        amp_d       = AMP_START;
        step_d      = STEP_START;
        blow_vld_d  = 1'b0;
        bhigh_vld_d = 1'b0;
        peak_d      = '0;
        phase_d     = PH_SEARCH;
        res_o.apply_gain = 1'b1;
      end else if (phase_q != PH_IDLE && acc_i.group_end) begin
        case (phase_q)
          PH_SEARCH: begin
            if (acc_i.avg > peak_q) begin
              peak_d = acc_i.avg;
            end
            if (acc_i.avg > threshold_i) begin
              bhigh_d     = amp_q;
              bhigh_vld_d = 1'b1;
              amp_d       = amp_q - half;
            end else begin
              blow_d     = amp_q;
              blow_vld_d = 1'b1;
              amp_d      = amp_q + half;
            end
            step_d = half;
            if (half == '0) begin
              if (bhigh_vld_d) begin
                amp_d   = blow_vld_d ? blow_d : bhigh_d;
                phase_d = PH_FINAL;
              end else if (pga_q == PGA_MAX) begin
                phase_d = PH_FINAL_GAVEUP;
              end else begin
                // nothing crossed the threshold: raise PGA and search again
                pga_d       = (pga_up > (PGA_W + 1)'(PGA_MAX)) ? PGA_MAX : pga_up[PGA_W-1:0];
                amp_d       = AMP_START;
                step_d      = STEP_START;
                blow_vld_d  = 1'b0;
                bhigh_vld_d = 1'b0;
                peak_d      = '0;
                res_o.apply_gain = 1'b1;
              end
            end
            if (amp_d != amp_q) begin
              res_o.apply_gain = 1'b1;
            end
          end
          PH_FINAL, PH_FINAL_GAVEUP: begin
            res_o.done_res   = 1'b1;
            res_o.gave_up    = phase_q == PH_FINAL_GAVEUP;
            res_o.final_rssi = acc_i.avg;
            phase_d          = PH_IDLE;
          end
          default: ;
        endcase
      end
    end

    res_o.amp_gain  = amp_d;
    res_o.pga_gain  = pga_d;
    res_o.peak_rssi = peak_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      amp_q       <= AMP_START;
      step_q      <= STEP_START;
      blow_vld_q  <= 1'b0;
      bhigh_vld_q <= 1'b0;
      pga_q       <= '0;
      peak_q      <= '0;
    end else begin
      phase_q     <= phase_d;
      amp_q       <= amp_d;
      step_q      <= step_d;
      blow_vld_q  <= blow_vld_d;
      bhigh_vld_q <= bhigh_vld_d;
      pga_q       <= pga_d;
      peak_q      <= peak_d;
    end
  end

  // best settings are meaningful only with their valid bits
  always_ff @(posedge clk_i) begin
    blow_q  <= blow_d;
    bhigh_q <= bhigh_d;
  end

endmodule

[rtl/rssi_gain_search_calibrator.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rssi_gain_search_calibrator
// Path: input beat to result beat through the input register, then
// search/average logic into the result register.
// Throughput: one beat per cycle while the output is not stalled; the input
// register refills while a result waits on a stalled output.
// Reset: search idle, amp gain 32, PGA gain 0, threshold 52428.
// ----------------------------------------------------------------------------
module rssi_gain_search_calibrator import rgsc_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic                  command_i,
  input  logic [RSSI_W-1:0]     rssi_sample_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [AMP_W-1:0]      amp_gain_o,
  output logic [PGA_W-1:0]      pga_gain_o,
  output logic                  apply_gain_o,
  output logic                  done_res_o,
  output logic                  gave_up_o,
  output logic [RSSI_W-1:0]     final_rssi_o,
  output logic [RSSI_W-1:0]     peak_rssi_o
);

  logic              a_valid_q, a_valid_d;
  logic              a_cmd_q;
  logic [RSSI_W-1:0] a_sample_q;
  logic              out_valid_q, out_valid_d;
  result_t           res_q;
  result_t           res;
  acc_res_t          acc;
  logic              out_load;
  logic              fire;
  logic              in_accept;
  logic              active;
  logic [RSSI_W-1:0] threshold;
  logic [PGA_W-1:0]  start_pga;

  assign out_load   = !out_valid_q || !out_stall_i;
  assign fire       = a_valid_q && out_load;
  assign in_stall_o = a_valid_q && !out_load;
  assign in_accept  = in_valid_i && !in_stall_o;

  rgsc_regs u_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .threshold_o (threshold),
    .start_pga_o (start_pga)
  );

  rgsc_accum u_accum (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .clear_i  (fire && a_cmd_q == CMD_START),
    .en_i     (fire && a_cmd_q == CMD_SAMPLE && active),
    .sample_i (a_sample_q),
    .acc_o    (acc)
  );

  rgsc_search u_search (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fire_i      (fire),
    .command_i   (a_cmd_q),
    .acc_i       (acc),
    .threshold_i (threshold),
    .start_pga_i (start_pga),
    .active_o    (active),
    .res_o       (res)
  );

  always_comb begin
    a_valid_d = a_valid_q;
    if (in_accept) begin
      a_valid_d = 1'b1;
    end else if (out_load) begin
      a_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = fire;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      a_valid_q   <= a_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      a_cmd_q    <= command_i;
      a_sample_q <= rssi_sample_i;
    end
    if (fire) begin
      res_q <= res;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign amp_gain_o   = res_q.amp_gain;
  assign pga_gain_o   = res_q.pga_gain;
  assign apply_gain_o = res_q.apply_gain;
  assign done_res_o   = res_q.done_res;
  assign gave_up_o    = res_q.gave_up;
  assign final_rssi_o = res_q.final_rssi;
  assign peak_rssi_o  = res_q.peak_rssi;

endmodule

[tb/tb_rssi_gain_search_calibrator.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_rssi_gain_search_calibrator
// Self-checking bench for the RSSI gain search calibrator. A behavioral copy
// of the binary gain search runs alongside the block and predicts one report
// per accepted beat. Directed beats cover ignored samples, rail-level groups,
// restarts and threshold compares. Random calibrations follow, shaped around
// the threshold, over several register settings and back-pressure mixes.
// ----------------------------------------------------------------------------
module tb_rssi_gain_search_calibrator;
  import rgsc_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int KEPT_PER_READ = (SAMPLES_PER_READ > SKIPPED_SAMPLES) ?
                                 (SAMPLES_PER_READ - SKIPPED_SAMPLES) : 1;

  typedef enum int {
    LVL_UNIFORM,
    LVL_RAMP,
    LVL_BELOW,
    LVL_ABOVE,
    LVL_RAILS
  } level_profile_e;

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  psel          = 1'b0;
  logic                  penable       = 1'b0;
  logic                  pwrite        = 1'b0;
  logic [APB_ADDR_W-1:0] paddr         = '0;
  logic [APB_DATA_W-1:0] pwdata        = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;
  logic                  in_valid_i    = 1'b0;
  logic                  in_stall_o;
  logic                  command_i     = CMD_SAMPLE;
  logic [RSSI_W-1:0]     rssi_sample_i = '0;
  logic                  out_valid_o;
  logic                  out_stall_i   = 1'b0;
  logic [AMP_W-1:0]      amp_gain_o;
  logic [PGA_W-1:0]      pga_gain_o;
  logic                  apply_gain_o;
  logic                  done_res_o;
  logic                  gave_up_o;
  logic [RSSI_W-1:0]     final_rssi_o;
  logic [RSSI_W-1:0]     peak_rssi_o;

  rssi_gain_search_calibrator DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .command_i     (command_i),
    .rssi_sample_i (rssi_sample_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .amp_gain_o    (amp_gain_o),
    .pga_gain_o    (pga_gain_o),
    .apply_gain_o  (apply_gain_o),
    .done_res_o    (done_res_o),
    .gave_up_o     (gave_up_o),
    .final_rssi_o  (final_rssi_o),
    .peak_rssi_o   (peak_rssi_o)
  );

  // shadow of the calibrator state
  phase_e            m_phase;
  logic [AMP_W-1:0]  m_amp;
  logic [AMP_W-1:0]  m_step;
  logic              m_lo_ok;
  logic [AMP_W-1:0]  m_lo;
  logic              m_hi_ok;
  logic [AMP_W-1:0]  m_hi;
  logic [PGA_W-1:0]  m_pga;
  int                m_idx;
  int                m_sum;
  logic [RSSI_W-1:0] m_peak;
  logic [RSSI_W-1:0] m_thr;
  logic [PGA_W-1:0]  m_start_pga;

  result_t     predicted_reports_q[$];
  int          fail_count;
  int unsigned cycle_count;
  int          sender_gap_pct;
  int          sink_stall_pct;

  always begin
    clk_i = 1'b0;
    #1;
    clk_i = 1'b1;
    #1;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    out_stall_i <= ($urandom_range(99) < sink_stall_pct);
  end

  initial begin
    wait (cycle_count == CYCLE_LIMIT);
    $display("rssi_gain_search_calibrator regression: fail");
    $finish;
  end

  function automatic void open_search_pass();
    m_amp   = AMP_START;
    m_step  = STEP_START;
    m_lo_ok = 1'b0;
    m_lo    = '0;
    m_hi_ok = 1'b0;
    m_hi    = '0;
    m_idx   = 0;
    m_sum   = 0;
    m_peak  = '0;
  endfunction

  function automatic void reset_search_shadow();
    m_thr       = THR_RESET;
    m_start_pga = '0;
    m_phase     = PH_IDLE;
    m_pga       = '0;
    open_search_pass();
  endfunction

  // One beat in, one report out.
  function automatic void advance_gain_search(input logic cmd, input logic [RSSI_W-1:0] smp);
    result_t           r;
    logic [AMP_W-1:0]  prev_amp;
    logic [AMP_W-1:0]  half;
    logic [PGA_W:0]    raised;
    logic [RSSI_W-1:0] avg;
    int                quot;
    r = '0;
    if (cmd == CMD_START) begin
      m_pga = m_start_pga;
      open_search_pass();
      m_phase = PH_SEARCH;
      r.apply_gain = 1'b1;
    end else if (m_phase != PH_IDLE) begin
      if (m_idx >= SKIPPED_SAMPLES) m_sum += smp;
      m_idx++;
      if (m_idx >= SAMPLES_PER_READ) begin
        quot  = m_sum / KEPT_PER_READ;
        avg   = (quot > 65535) ? 16'hFFFF : quot[RSSI_W-1:0];
        m_sum = 0;
        m_idx = 0;
        if (m_phase == PH_SEARCH) begin
          prev_amp = m_amp;
          half     = m_step >> 1;
          if (avg > m_peak) m_peak = avg;
          if (avg > m_thr) begin
            m_hi    = m_amp;
            m_hi_ok = 1'b1;
            m_amp   = m_amp - half;
          end else begin
            m_lo    = m_amp;
            m_lo_ok = 1'b1;
            m_amp   = m_amp + half;
          end
          m_step = half;
          if (m_step == '0) begin
            if (m_hi_ok) begin
              m_amp   = m_lo_ok ? m_lo : m_hi;
              m_phase = PH_FINAL;
            end else if (m_pga == PGA_MAX) begin
              m_phase = PH_FINAL_GAVEUP;
            end else begin
              // nothing crossed: more PGA gain and a fresh pass
              raised = {1'b0, m_pga} + PGA_RETRY_UP;
              m_pga  = (raised > {1'b0, PGA_MAX}) ? PGA_MAX : raised[PGA_W-1:0];
              open_search_pass();
              r.apply_gain = 1'b1;
            end
          end
          if (m_amp != prev_amp) r.apply_gain = 1'b1;
        end else begin
          r.done_res   = 1'b1;
          r.gave_up    = (m_phase == PH_FINAL_GAVEUP);
          r.final_rssi = avg;
          m_phase      = PH_IDLE;
        end
      end
    end
    r.amp_gain  = m_amp;
    r.pga_gain  = m_pga;
    r.peak_rssi = m_peak;
    predicted_reports_q.push_back(r);
  endfunction

  // Leaves valid high on return; the next beat or a drain takes it over.
  task automatic send_beat(input logic cmd, input logic [RSSI_W-1:0] smp);
    logic taken;
    while ($urandom_range(99) < sender_gap_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    command_i     <= cmd;
    rssi_sample_i <= smp;
    advance_gain_search(cmd, smp);
    do begin
      @(negedge clk_i);
      taken = !in_stall_o;
      @(posedge clk_i);
    end while (!taken);
  endtask

  task automatic drain_reports();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (predicted_reports_q.size() != 0);
  endtask

  task automatic write_reg(input logic idx, input logic [APB_DATA_W-1:0] val);
    logic ready;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    do begin
      @(negedge clk_i);
      ready = pready;
      @(posedge clk_i);
    end while (!ready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == REG_THRESHOLD) m_thr = val[RSSI_W-1:0];
    else m_start_pga = val[PGA_W-1:0];
    @(posedge clk_i);
  endtask

  task automatic set_config(input logic [RSSI_W-1:0] thr, input logic [PGA_W-1:0] pga);
    drain_reports();
    repeat (4) @(posedge clk_i);
    write_reg(REG_THRESHOLD, APB_DATA_W'(thr));
    write_reg(REG_START_PGA, APB_DATA_W'(pga));
  endtask

  function automatic logic [RSSI_W-1:0] pick_level(input level_profile_e prof,
                                                    input int target, input int slope);
    int lvl;
    case (prof)
      LVL_RAMP: begin
        // level climbs with amp gain and crosses the threshold near target
        lvl = int'(m_thr) + (int'(m_amp) - target) * slope + int'($urandom_range(64)) - 32;
      end
      LVL_BELOW: lvl = $urandom_range(m_thr, 0);
      LVL_ABOVE: lvl = (m_thr == 16'hFFFF) ? 65535 : $urandom_range(65535, m_thr + 1);
      LVL_RAILS: lvl = $urandom_range(1) ? 65535 : 0;
      default:   lvl = $urandom_range(65535);
    endcase
    if (lvl < 0) lvl = 0;
    if (lvl > 65535) lvl = 65535;
    return lvl[RSSI_W-1:0];
  endfunction

  task automatic check_field(input string name, input int unsigned want, input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endtask

  always @(negedge clk_i) begin : report_check
    result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (predicted_reports_q.size() == 0) begin
        $error("report beat with nothing predicted");
        fail_count++;
      end else begin
        want = predicted_reports_q.pop_front();
        check_field("amp_gain", want.amp_gain, amp_gain_o);
        check_field("pga_gain", want.pga_gain, pga_gain_o);
        check_field("apply_gain", want.apply_gain, apply_gain_o);
        check_field("done_res", want.done_res, done_res_o);
        check_field("gave_up", want.gave_up, gave_up_o);
        check_field("final_rssi", want.final_rssi, final_rssi_o);
        check_field("peak_rssi", want.peak_rssi, peak_rssi_o);
      end
    end
  end

  // samples before any start are dropped by the block
  task automatic test_ignored_samples();
    send_beat(CMD_SAMPLE, 16'h0000);
    send_beat(CMD_SAMPLE, 16'hFFFF);
    send_beat(CMD_SAMPLE, 16'hA5A5);
  endtask

  // full-scale group steps down, zero group steps up, then restart mid-group
  task automatic test_rail_groups();
    send_beat(CMD_START, 16'hFFFF);
    repeat (SAMPLES_PER_READ) send_beat(CMD_SAMPLE, 16'hFFFF);
    repeat (SAMPLES_PER_READ) send_beat(CMD_SAMPLE, 16'h0000);
    send_beat(CMD_SAMPLE, 16'h5A5A);
    send_beat(CMD_SAMPLE, 16'hFFFF);
    send_beat(CMD_START, 16'h0000);
  endtask

  // average equal to the threshold is not above it; truncation matters
  task automatic test_threshold_compare();
    set_config(16'd1000, PGA_MAX);
    send_beat(CMD_START, 16'h0000);
    send_beat(CMD_SAMPLE, 16'hFFFF);
    repeat (SAMPLES_PER_READ - 1) send_beat(CMD_SAMPLE, 16'd1000);
    send_beat(CMD_SAMPLE, 16'h0000);
    repeat (SAMPLES_PER_READ - 1) send_beat(CMD_SAMPLE, 16'd1001);
    send_beat(CMD_SAMPLE, 16'hFFFF);
    send_beat(CMD_SAMPLE, 16'd1000);
    send_beat(CMD_SAMPLE, 16'd1000);
    send_beat(CMD_SAMPLE, 16'd1002);
  endtask

  task automatic test_random_calibrations(input int n_items);
    int             sent;
    int             target;
    int             slope;
    int             cap;
    level_profile_e prof;
    sent = 0;
    while (sent < n_items) begin
      prof   = level_profile_e'($urandom_range(4));
      target = $urandom_range(63);
      slope  = $urandom_range(600, 1);
      // now and then a calibration is abandoned part way
      cap    = ($urandom_range(9) == 0) ? $urandom_range(30, 1) : 400;
      send_beat(CMD_START, RSSI_W'($urandom));
      sent++;
      for (int k = 0; k < cap && m_phase != PH_IDLE && sent < n_items; k++) begin
        if ($urandom_range(79) == 0) send_beat(CMD_START, RSSI_W'($urandom));
        else send_beat(CMD_SAMPLE, pick_level(prof, target, slope));
        sent++;
        if ($urandom_range(149) == 0) drain_reports();
      end
      repeat ($urandom_range(2)) begin
        send_beat(CMD_SAMPLE, RSSI_W'($urandom));
        sent++;
      end
    end
  endtask

  initial begin
    fail_count     = 0;
    sender_gap_pct = 20;
    sink_stall_pct = 48;
    reset_search_shadow();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_ignored_samples();
    test_rail_groups();
    test_threshold_compare();
    test_random_calibrations(250);
    set_config(16'd0, 5'd0);
    test_random_calibrations(150);

    sender_gap_pct = 48;
    sink_stall_pct = 20;
    set_config(16'hFFFF, PGA_MAX);
    test_random_calibrations(120);
    set_config(RSSI_W'($urandom), PGA_W'($urandom));
    test_random_calibrations(250);

    sender_gap_pct = 0;
    sink_stall_pct = 0;
    set_config(THR_RESET, 5'd0);
    test_random_calibrations(200);
    set_config(RSSI_W'($urandom), PGA_W'($urandom));
    test_random_calibrations(180);

    drain_reports();
    repeat (8) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("rssi_gain_search_calibrator regression: pass");
    end else begin
      $display("rssi_gain_search_calibrator regression: fail");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/rgsc_pkg.sv
rtl/rgsc_regs.sv
rtl/rgsc_accum.sv
rtl/rgsc_search.sv
rtl/rssi_gain_search_calibrator.sv
tb/tb_rssi_gain_search_calibrator.sv
